[rtl/core/fwcrc_pkg.sv]
// ----------------------------------------------------------------------------
// fwcrc_pkg
// shared types, phase codes, verdict codes and the crc-32 byte fold
// ----------------------------------------------------------------------------
`default_nettype none

package fwcrc_pkg;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CRC    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_BAD_MAGIC = 3'd1;
    localparam logic [2:0] VERDICT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] VERDICT_TOO_LARGE = 3'd3;
    localparam logic [2:0] VERDICT_BAD_CRC   = 3'd4;

    localparam logic [1:0] REG_MAGIC_LOW    = 2'd0;
    localparam logic [1:0] REG_MAGIC_HIGH   = 2'd1;
    localparam logic [1:0] REG_MAGIC_LENGTH = 2'd2;
    localparam logic [1:0] REG_IMAGE_SIZE   = 2'd3;

    localparam int          CFG_INDEX_W  = 8;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET   = 32'hFFFF_FFFF;
    localparam logic [31:0] SIZE_MASK    = 32'hFFFF_FFFC;
    localparam logic [4:0]  HEADER_BYTES = 5'd16;

    typedef struct packed {
        logic [63:0] magic_low;
        logic [63:0] magic_high;
        logic [4:0]  magic_length;
        logic [31:0] image_size;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        truncated;
        logic [1:0]  failed_section;
        logic [31:0] computed_crc;
    } result_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/firmware_image_crc_verifier.sv]
// ----------------------------------------------------------------------------
// firmware_image_crc_verifier
// byte-stream firmware image checker with crc-32 and one verdict per image
// ----------------------------------------------------------------------------
// The block takes one image byte per clock and updates its parser state and
// running crc in the same cycle; each byte is one transaction. A byte that
// decides the image (or the tlast byte of an unfinished image) loads a
// single result register, so its verdict appears on the master side in the
// cycle after that byte's transaction. s_tready is low only while that
// register is full and m_tready is low, so with a free output side the
// block sustains one byte per cycle. Configuration writes are always
// taken and should be made between images. No clearing pass after reset.
`default_nettype none

module firmware_image_crc_verifier
    import fwcrc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]            cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // data_byte[7:0]
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [39:0]                 m_tdata,   // verdict[2:0], failed_section[4:3],
                                                   // computed_crc[36:5], zero[39:37]
    output logic                        m_tuser    // truncated
);

    cfg_t    cfg_reg;
    logic    step;
    logic    res_valid;
    result_t res;
    logic    room;
    logic    out_valid;
    result_t out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && (cfg_index[CFG_INDEX_W-1:2] == '0))
        begin
            case (cfg_index[1:0])
                REG_MAGIC_LOW:    cfg_reg.magic_low    <= cfg_data;
                REG_MAGIC_HIGH:   cfg_reg.magic_high   <= cfg_data;
                REG_MAGIC_LENGTH: cfg_reg.magic_length <= cfg_data[4:0];
                REG_IMAGE_SIZE:   cfg_reg.image_size   <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = room;
    assign step     = s_tvalid && room;

    fwcrc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fwcrc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_data (res),
        .take      (m_tready),
        .room      (room),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {3'd0, out_data.computed_crc, out_data.failed_section, out_data.verdict};
    assign m_tuser  = out_data.truncated;

endmodule

`default_nettype wire

[rtl/core/fwcrc_parser.sv]
// ----------------------------------------------------------------------------
// fwcrc_parser
// image parser state, crc accumulation and verdict decision for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module fwcrc_parser
    import fwcrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output result_t         res
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [1:0]  section_reg, section_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] remain_reg, remain_next;
    logic        given_reg, given_next;

    always_comb
    begin
        logic [4:0]   mlen;
        logic [127:0] magic_all;
        logic [7:0]   magic_b;
        logic [31:0]  cnt_inc;
        logic [31:0]  shift_new;
        logic [31:0]  rounded;
        logic [31:0]  remain_cur;
        logic [31:0]  crc_new;
        logic         hit;
        logic [2:0]   v;
        logic [1:0]   sect;

        phase_next   = phase_reg;
        count_next   = count_reg;
        section_next = section_reg;
        crc_next     = crc_reg;
        shift_next   = shift_reg;
        remain_next  = remain_reg;
        given_next   = given_reg;
        hit          = 1'b0;
        v            = VERDICT_OK;
        sect         = 2'd0;

        mlen       = (cfg.magic_length > HEADER_BYTES) ? HEADER_BYTES : cfg.magic_length;
        magic_all  = {cfg.magic_high, cfg.magic_low};
        magic_b    = magic_all[{count_reg[3:0], 3'b000} +: 8];
        cnt_inc    = count_reg + 32'd1;
        shift_new  = shift_reg | ({24'd0, data_byte} << {count_reg[1:0], 3'b000});
        rounded    = (shift_new + 32'd3) & SIZE_MASK;
        remain_cur = remain_reg;
        crc_new    = crc_fold(crc_reg, data_byte);

        if (!given_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (count_reg == 32'd0)
                    begin
                        remain_next = cfg.image_size;
                    end
                    crc_next = crc_new;
                    if ((count_reg < {27'd0, mlen}) && (data_byte != magic_b))
                    begin
                        v   = VERDICT_BAD_MAGIC;
                        hit = 1'b1;
                    end
                    else if (cnt_inc >= {27'd0, HEADER_BYTES})
                    begin
                        phase_next = PH_TYPE;
                        count_next = 32'd0;
                        shift_next = 32'd0;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
                PH_TYPE, PH_SIZE:
                begin
                    crc_next   = crc_new;
                    shift_next = shift_new;
                    count_next = cnt_inc;
                    if (cnt_inc >= 32'd4)
                    begin
                        if (phase_reg == PH_TYPE)
                        begin
                            if (shift_new != {30'd0, section_reg})
                            begin
                                v    = VERDICT_BAD_TYPE;
                                sect = section_reg;
                                hit  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_SIZE;
                                count_next = 32'd0;
                                shift_next = 32'd0;
                            end
                        end
                        else if (remain_cur < rounded)
                        begin
                            v    = VERDICT_TOO_LARGE;
                            sect = section_reg;
                            hit  = 1'b1;
                        end
                        else
                        begin
                            remain_next = remain_cur - rounded;
                            shift_next  = 32'd0;
                            if (rounded == 32'd0)
                            begin
                                count_next = 32'd0;
                                if (section_reg == 2'd1)
                                begin
                                    section_next = 2'd2;
                                    phase_next   = PH_TYPE;
                                end
                                else
                                begin
                                    phase_next = PH_CRC;
                                end
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                count_next = rounded;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc_new;
                    if (count_reg <= 32'd1)
                    begin
                        count_next = 32'd0;
                        shift_next = 32'd0;
                        if (section_reg == 2'd1)
                        begin
                            section_next = 2'd2;
                            phase_next   = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_CRC;
                        end
                    end
                    else
                    begin
                        count_next = count_reg - 32'd1;
                    end
                end
                PH_CRC:
                begin
                    shift_next = shift_new;
                    count_next = cnt_inc;
                    if (cnt_inc >= 32'd4)
                    begin
                        v   = (shift_new == ~crc_reg) ? VERDICT_OK : VERDICT_BAD_CRC;
                        hit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res_valid          = 1'b0;
        res.verdict        = v;
        res.truncated      = 1'b0;
        res.failed_section = sect;
        res.computed_crc   = ~crc_next;

        if (hit)
        begin
            res_valid  = 1'b1;
            given_next = 1'b1;
            phase_next = PH_DONE;
        end
        else if (last_byte && !given_reg)
        begin
            res_valid          = 1'b1;
            res.verdict        = VERDICT_BAD_CRC;
            res.truncated      = 1'b1;
            res.failed_section = ((phase_next == PH_TYPE) || (phase_next == PH_SIZE) ||
                                  (phase_next == PH_DATA)) ? section_next : 2'd0;
        end

        if (last_byte)
        begin
            phase_next   = PH_HEADER;
            count_next   = 32'd0;
            section_next = 2'd1;
            crc_next     = CRC_PRESET;
            shift_next   = 32'd0;
            remain_next  = 32'd0;
            given_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            count_reg   <= 32'd0;
            section_reg <= 2'd1;
            crc_reg     <= CRC_PRESET;
            shift_reg   <= 32'd0;
            remain_reg  <= 32'd0;
            given_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            section_reg <= section_next;
            crc_reg     <= crc_next;
            shift_reg   <= shift_next;
            remain_reg  <= remain_next;
            given_reg   <= given_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fwcrc_out_reg.sv]
// ----------------------------------------------------------------------------
// fwcrc_out_reg
// result register holding one verdict until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module fwcrc_out_reg
    import fwcrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    take,
    output logic         room,
    output logic         out_valid,
    output result_t      out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign room       = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the firmware image crc verifier. Whole images are
// fed as byte transactions: clean ones with random content, and ones with a
// broken magic, section type, section size or crc, cut short, or pure noise.
// The register settings change between groups of images. A model of the
// parser predicts the verdict of every upload, and each result transaction
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fwcrc_pkg::*;

    localparam int          SETTLE_CYCLES   = 4;
    localparam int          STUCK_LIMIT     = 2000;
    localparam int          TARGET_BYTES    = 1250;
    localparam int          TARGET_UPLOADS  = 20;
    localparam logic [7:0]  SPARE_REG_INDEX = 8'hFF;

    typedef enum logic [1:0] {STEP_BYTE, STEP_WRITE, STEP_DRAIN} step_kind_e;

    typedef enum {FLAW_NONE, FLAW_MAGIC, FLAW_TYPE, FLAW_SIZE, FLAW_CRC, FLAW_CUT, FLAW_NOISE}
        flaw_e;

    typedef struct {
        step_kind_e  kind;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  reg_index;
        logic [63:0] value;
        int unsigned gap;
    } step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [39:0]            m_tdata;
    logic                   m_tuser;

    step_t       pending[$];
    result_t     verdicts_due[$];
    cfg_t        plan_cfg = '0;
    cfg_t        model_cfg = '0;

    // parser model state
    logic [2:0]  scan_phase;
    logic [31:0] scan_count;
    logic [1:0]  scan_section;
    logic [31:0] scan_crc;
    logic [31:0] scan_word;
    logic [31:0] scan_budget;
    logic        scan_decided;

    int          mismatches = 0;
    int          stuck_cycles = 0;
    int          quiet_cycles = 0;
    int unsigned gap_wait = 0;
    int          stall_left = 0;
    int          calm_results = 0;
    int          calm_bytes = 0;
    int          queued_bytes = 0;
    int          uploads = 0;
    logic        byte_busy;
    logic        write_busy;
    result_t     got;
    result_t     want;

    firmware_image_crc_verifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        repeat (8)
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        return c;
    endfunction

    function automatic void rearm_scan();
        scan_phase   = PH_HEADER;
        scan_count   = 0;
        scan_section = 2'd1;
        scan_crc     = CRC_PRESET;
        scan_word    = 0;
        scan_budget  = 0;
        scan_decided = 1'b0;
    endfunction

    function automatic void close_section();
        if (scan_section == 2'd1)
        begin
            scan_section = 2'd2;
            scan_phase   = PH_TYPE;
        end
        else
            scan_phase = PH_CRC;
        scan_count = 0;
        scan_word  = 0;
    endfunction

    // one image byte through the parser model; queues a verdict when one falls
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic          hit;
        result_t       due;
        logic [4:0]    mlen;
        logic [31:0]   rounded;
        logic [127:0]  magic;
        hit   = 1'b0;
        due   = '0;
        magic = {model_cfg.magic_high, model_cfg.magic_low};
        if (!scan_decided)
        begin
            case (scan_phase)
                PH_HEADER:
                begin
                    if (scan_count == 0)
                        scan_budget = model_cfg.image_size;
                    mlen = (model_cfg.magic_length > HEADER_BYTES) ? HEADER_BYTES
                                                                   : model_cfg.magic_length;
                    scan_crc = crc32_byte(scan_crc, b);
                    if (scan_count < {27'd0, mlen} && b != magic[scan_count[3:0] * 8 +: 8])
                    begin
                        due.verdict = VERDICT_BAD_MAGIC;
                        hit = 1'b1;
                    end
                    else
                    begin
                        scan_count = scan_count + 1;
                        if (scan_count >= 16)
                        begin
                            scan_phase = PH_TYPE;
                            scan_count = 0;
                            scan_word  = 0;
                        end
                    end
                end
                PH_TYPE, PH_SIZE:
                begin
                    scan_crc   = crc32_byte(scan_crc, b);
                    scan_word  = scan_word | ({24'd0, b} << {scan_count[1:0], 3'b000});
                    scan_count = scan_count + 1;
                    if (scan_count >= 4)
                    begin
                        if (scan_phase == PH_TYPE)
                        begin
                            if (scan_word != {30'd0, scan_section})
                            begin
                                due.verdict        = VERDICT_BAD_TYPE;
                                due.failed_section = scan_section;
                                hit = 1'b1;
                            end
                            else
                            begin
                                scan_phase = PH_SIZE;
                                scan_count = 0;
                                scan_word  = 0;
                            end
                        end
                        else
                        begin
                            rounded = (scan_word + 32'd3) & SIZE_MASK;
                            if (scan_budget < rounded)
                            begin
                                due.verdict        = VERDICT_TOO_LARGE;
                                due.failed_section = scan_section;
                                hit = 1'b1;
                            end
                            else
                            begin
                                scan_budget = scan_budget - rounded;
                                if (rounded == 0)
                                    close_section();
                                else
                                begin
                                    scan_phase = PH_DATA;
                                    scan_count = rounded;
                                    scan_word  = 0;
                                end
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    scan_crc = crc32_byte(scan_crc, b);
                    if (scan_count > 0)
                        scan_count = scan_count - 1;
                    if (scan_count == 0)
                        close_section();
                end
                PH_CRC:
                begin
                    scan_word  = scan_word | ({24'd0, b} << {scan_count[1:0], 3'b000});
                    scan_count = scan_count + 1;
                    if (scan_count >= 4)
                    begin
                        due.verdict = (scan_word == ~scan_crc) ? VERDICT_OK : VERDICT_BAD_CRC;
                        hit = 1'b1;
                    end
                end
                default:
                    ;
            endcase
        end
        if (hit)
        begin
            due.computed_crc = ~scan_crc;
            verdicts_due.push_back(due);
            scan_decided = 1'b1;
            scan_phase   = PH_DONE;
        end
        else if (last && !scan_decided)
        begin
            due.verdict   = VERDICT_BAD_CRC;
            due.truncated = 1'b1;
            if (scan_phase == PH_TYPE || scan_phase == PH_SIZE || scan_phase == PH_DATA)
                due.failed_section = scan_section;
            due.computed_crc = ~scan_crc;
            verdicts_due.push_back(due);
        end
        if (last)
            rearm_scan();
    endtask

    // ------------------------------------------------------------------ stimulus

    task automatic push_byte(input logic [7:0] b, input logic last);
        step_t st;
        st = '{kind: STEP_BYTE, data: b, last: last, reg_index: '0, value: '0, gap: 0};
        if (calm_bytes > 0)
            calm_bytes--;
        else
        begin
            if ($urandom_range(0, 39) == 0)
                calm_bytes = 60;
            st.gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
        end
        pending.push_back(st);
        queued_bytes++;
    endtask

    task automatic push_write(input logic [7:0] idx, input logic [63:0] value);
        pending.push_back('{kind: STEP_WRITE, data: '0, last: 1'b0, reg_index: idx,
                            value: value, gap: 0});
    endtask

    task automatic push_drain();
        pending.push_back('{kind: STEP_DRAIN, data: '0, last: 1'b0, reg_index: '0,
                            value: '0, gap: 0});
    endtask

    task automatic program_checker(input logic [63:0] low, input logic [63:0] high,
                                   input logic [4:0] len, input logic [31:0] size);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        push_write(CFG_INDEX_W'(REG_MAGIC_LOW), low);
        push_write(CFG_INDEX_W'(REG_MAGIC_HIGH), high);
        push_write(CFG_INDEX_W'(REG_MAGIC_LENGTH), {junk[63:5], len});
        push_write(CFG_INDEX_W'(REG_IMAGE_SIZE), {junk[63:32], size});
        plan_cfg.magic_low    = low;
        plan_cfg.magic_high   = high;
        plan_cfg.magic_length = len;
        plan_cfg.image_size   = size;
    endtask

    task automatic add_word(ref logic [7:0] img[$], input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            img.push_back(w[k * 8 +: 8]);
    endtask

    function automatic logic [31:0] pick_size(input logic [31:0] left);
        logic [31:0] cap;
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFD + $urandom_range(0, 2);
            1:       return 0;
            default:
            begin
                cap = ((left > 12) ? 32'd12 : left) & SIZE_MASK;
                return $urandom_range(0, cap);
            end
        endcase
    endfunction

    task automatic queue_upload();
        logic [7:0]   img[$];
        logic [127:0] magic;
        logic [31:0]  left;
        logic [31:0]  size;
        logic [31:0]  rounded;
        logic [31:0]  crc_acc;
        logic [31:0]  word;
        logic [4:0]   mlen;
        logic         stop;
        int           bad_sect;
        int           cut;
        flaw_e        flaw;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: flaw = FLAW_NONE;
            5:             flaw = FLAW_MAGIC;
            6:             flaw = FLAW_TYPE;
            7:             flaw = FLAW_SIZE;
            8:             flaw = FLAW_CRC;
            9, 10:         flaw = FLAW_CUT;
            default:       flaw = FLAW_NOISE;
        endcase
        stop     = 1'b0;
        bad_sect = $urandom_range(1, 2);
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 40))
                img.push_back(8'($urandom));
        end
        else
        begin
            magic = {plan_cfg.magic_high, plan_cfg.magic_low};
            mlen  = (plan_cfg.magic_length > HEADER_BYTES) ? HEADER_BYTES
                                                           : plan_cfg.magic_length;
            for (int i = 0; i < 16; i++)
                img.push_back((i < mlen) ? magic[i * 8 +: 8] : 8'($urandom));
            if (flaw == FLAW_MAGIC && mlen > 0)
            begin
                cut = $urandom_range(0, mlen - 1);
                img[cut] = img[cut] ^ (8'd1 << $urandom_range(0, 7));
            end
            left = plan_cfg.image_size;
            for (int s = 1; s <= 2 && !stop; s++)
            begin
                word = s;
                if (flaw == FLAW_TYPE && s == bad_sect)
                    word = word ^ (32'd1 << $urandom_range(0, 31));
                add_word(img, word);
                if (flaw == FLAW_SIZE && s == bad_sect && left < 32'hFFFF_FFF0)
                    size = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFC
                                                       : left + 1 + $urandom_range(0, 5);
                else
                    size = pick_size(left);
                add_word(img, size);
                rounded = (size + 32'd3) & SIZE_MASK;
                if (rounded > left)
                    stop = 1'b1;
                else
                begin
                    left = left - rounded;
                    repeat (rounded)
                        img.push_back(8'($urandom));
                end
            end
            if (!stop)
            begin
                crc_acc = CRC_PRESET;
                foreach (img[k])
                    crc_acc = crc32_byte(crc_acc, img[k]);
                word = ~crc_acc;
                if (flaw == FLAW_CRC)
                    word = word ^ (32'd1 << $urandom_range(0, 31));
                add_word(img, word);
            end
        end
        // trailing bytes after the decision are ignored by the parser
        repeat ($urandom_range(0, 3))
            img.push_back(8'($urandom));
        if (flaw == FLAW_CUT && img.size() > 1)
        begin
            cut = $urandom_range(1, img.size() - 1);
            while (img.size() > cut)
                void'(img.pop_back());
        end
        foreach (img[k])
            push_byte(img[k], k == img.size() - 1);
        uploads++;
    endtask

    // ------------------------------------------------------------------ clock and run

    initial
    begin
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        int group;
        rearm_scan();

        // short uploads on reset settings, then a tiny magic
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_write(SPARE_REG_INDEX, {$urandom, $urandom});
        program_checker(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd2, 32'd0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hCD, 1'b1);
        push_byte(8'hEF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h55, 1'b1);

        group = 0;
        while (queued_bytes < TARGET_BYTES || uploads < TARGET_UPLOADS)
        begin
            case (group)
                0: program_checker({$urandom, $urandom}, {$urandom, $urandom}, 5'd16,
                                   32'hFFFF_FFFF);
                1: program_checker(64'd0, 64'd0, 5'd0, 32'd0);
                2: program_checker('1, '1, 5'd31, $urandom_range(20, 80));
                3: program_checker({$urandom, $urandom}, {$urandom, $urandom},
                                   5'($urandom_range(1, 15)), $urandom_range(0, 64));
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: plan_cfg.image_size = $urandom_range(0, 24);
                        1: plan_cfg.image_size = $urandom_range(24, 96);
                        2: plan_cfg.image_size = $urandom;
                        default: plan_cfg.image_size = 32'hFFFF_FFFF;
                    endcase
                    program_checker({$urandom, $urandom}, {$urandom, $urandom},
                                    5'($urandom_range(0, 31)), plan_cfg.image_size);
                end
            endcase
            repeat (4)
            begin
                queue_upload();
                if (group == 0 || $urandom_range(0, 4) == 0)
                    push_drain();
            end
            group++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid || cfg_valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(negedge clk);
        $display("%0t ns: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------ driver

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_busy  = s_tvalid;
            write_busy = cfg_valid;
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
                byte_busy    = 1'b0;
                quiet_cycles = 0;
            end
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles++;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INDEX_W'(REG_MAGIC_LOW):    model_cfg.magic_low    = cfg_data;
                    CFG_INDEX_W'(REG_MAGIC_HIGH):   model_cfg.magic_high   = cfg_data;
                    CFG_INDEX_W'(REG_MAGIC_LENGTH): model_cfg.magic_length = cfg_data[4:0];
                    CFG_INDEX_W'(REG_IMAGE_SIZE):   model_cfg.image_size   = cfg_data[31:0];
                    default:          ;
                endcase
                write_busy = 1'b0;
            end
            if (!byte_busy && !write_busy && pending.size() != 0)
            begin
                if (gap_wait < pending[0].gap)
                    gap_wait++;
                else
                begin
                    case (pending[0].kind)
                        STEP_BYTE:
                        begin
                            s_tdata  <= pending[0].data;
                            s_tlast  <= pending[0].last;
                            byte_busy = 1'b1;
                            gap_wait  = 0;
                            void'(pending.pop_front());
                        end
                        STEP_WRITE:
                        begin
                            if (verdicts_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                            begin
                                cfg_index  <= pending[0].reg_index;
                                cfg_data   <= pending[0].value;
                                write_busy  = 1'b1;
                                void'(pending.pop_front());
                            end
                        end
                        default:
                        begin
                            if (verdicts_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                                void'(pending.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid  <= byte_busy;
            cfg_valid <= write_busy;
        end
    end

    // ------------------------------------------------------------------ monitor

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.verdict        = m_tdata[2:0];
                got.failed_section = m_tdata[4:3];
                got.computed_crc   = m_tdata[36:5];
                got.truncated      = m_tuser;
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, got verdict %0d",
                             $time, got.verdict);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got.verdict != want.verdict)
                    begin
                        $display("%0t ns: verdict expected %0d, got %0d",
                                 $time, want.verdict, got.verdict);
                        mismatches++;
                    end
                    if (got.truncated != want.truncated)
                    begin
                        $display("%0t ns: truncated expected %0b, got %0b",
                                 $time, want.truncated, got.truncated);
                        mismatches++;
                    end
                    if (got.failed_section != want.failed_section)
                    begin
                        $display("%0t ns: failed_section expected %0d, got %0d",
                                 $time, want.failed_section, got.failed_section);
                        mismatches++;
                    end
                    if (got.computed_crc != want.computed_crc)
                    begin
                        $display("%0t ns: computed_crc expected %08h, got %08h",
                                 $time, want.computed_crc, got.computed_crc);
                        mismatches++;
                    end
                end
                // receiver stall for the next transaction
                if (calm_results > 0)
                begin
                    calm_results--;
                    stall_left = 0;
                end
                else
                begin
                    if ($urandom_range(0, 24) == 0)
                        calm_results = 30;
                    stall_left = $urandom_range(0, 11);
                end
            end
            else if (stall_left > 0)
                stall_left--;
            m_tready <= (stall_left == 0);
        end
    end

endmodule

[sim.f]
rtl/core/fwcrc_pkg.sv
rtl/core/fwcrc_parser.sv
rtl/core/fwcrc_out_reg.sv
rtl/core/firmware_image_crc_verifier.sv
verif/testbench.sv
